FILE: design/jse_pkg.sv
package jse_pkg;

   localparam int MaxBeats = 8;
   localparam int IdxBits  = $clog2(MaxBeats);
   localparam int CntBits  = $clog2(MaxBeats + 1);

   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5c;
   localparam logic [7:0] ChLower_u   = 8'h75;
   localparam logic [7:0] ChZero      = 8'h30;

   localparam logic [7:0] CtlBs  = 8'h08;
   localparam logic [7:0] CtlTab = 8'h09;
   localparam logic [7:0] CtlLf  = 8'h0a;
   localparam logic [7:0] CtlFf  = 8'h0c;
   localparam logic [7:0] CtlCr  = 8'h0d;

   localparam logic [7:0]  LeadTwoLo   = 8'hc2;
   localparam logic [7:0]  LeadTwoHi   = 8'hdf;
   localparam logic [7:0]  LeadThreeLo = 8'he0;
   localparam logic [7:0]  LeadThreeHi = 8'hef;
   localparam logic [7:0]  LeadFourLo  = 8'hf0;
   localparam logic [7:0]  LeadFourHi  = 8'hf4;
   localparam logic [20:0] MinTwo      = 21'h000080;
   localparam logic [20:0] MinThree    = 21'h000800;
   localparam logic [20:0] MinFour     = 21'h010000;
   localparam logic [20:0] MaxCode     = 21'h10ffff;
   localparam logic [20:0] SurrLo      = 21'h00d800;
   localparam logic [20:0] SurrHi      = 21'h00dfff;

   typedef struct packed {
      logic [MaxBeats-1:0][7:0] bytes;
      logic [CntBits-1:0]       count;
      logic                     has_close;
      logic                     bad;
   } seq_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage

FILE: design/jse_ifs.sv
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       string_start;
   logic       string_end;

   modport source (output valid, output data_byte, output byte_present,
                   output string_start, output string_end, input ready);
   modport sink   (input valid, input data_byte, input byte_present,
                   input string_start, input string_end, output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       closing_quote;
   logic       utf8_invalid;

   modport source (output valid, output out_byte, output out_last,
                   output closing_quote, output utf8_invalid, input ready);
   modport sink   (input valid, input out_byte, input out_last,
                   input closing_quote, input utf8_invalid, output ready);
endinterface

FILE: design/jse_utf8_check.sv
module jse_utf8_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       byte_present,
   input  logic       string_start,
   input  logic       string_end,
   output logic       verdict_bad
);

   logic [1:0]  pend_ff, pend_in;
   logic [20:0] code_ff, code_in;
   logic [1:0]  class_ff, class_in;
   logic        inv_ff, inv_in;

   logic [1:0]  pend;
   logic [20:0] code;
   logic [1:0]  cls;
   logic        inv;
   logic [20:0] shifted;
   logic [20:0] minimum;

   always_comb begin
      pend = string_start ? 2'd0  : pend_ff;
      code = string_start ? 21'd0 : code_ff;
      cls  = string_start ? 2'd0  : class_ff;
      inv  = string_start ? 1'b0  : inv_ff;
      shifted = {code[14:0], data_byte[5:0]};
      case (cls)
         2'd1:    minimum = jse_pkg::MinTwo;
         2'd2:    minimum = jse_pkg::MinThree;
         default: minimum = jse_pkg::MinFour;
      endcase

      if (byte_present) begin
         if (pend == 2'd0) begin
            if (data_byte[7] == 1'b0) begin
               // ascii, nothing to track
            end else if (data_byte inside {[jse_pkg::LeadTwoLo:jse_pkg::LeadTwoHi]}) begin
               pend = 2'd1;
               code = {16'd0, data_byte[4:0]};
               cls  = 2'd1;
            end else if (data_byte inside
                         {[jse_pkg::LeadThreeLo:jse_pkg::LeadThreeHi]}) begin
               pend = 2'd2;
               code = {17'd0, data_byte[3:0]};
               cls  = 2'd2;
            end else if (data_byte inside
                         {[jse_pkg::LeadFourLo:jse_pkg::LeadFourHi]}) begin
               pend = 2'd3;
               code = {18'd0, data_byte[2:0]};
               cls  = 2'd3;
            end else begin
               inv = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            inv  = 1'b1;
            pend = 2'd0;
            code = 21'd0;
            cls  = 2'd0;
         end else begin
            pend = pend - 2'd1;
            if (pend == 2'd0) begin
               if (shifted < minimum || shifted > jse_pkg::MaxCode ||
                   (shifted >= jse_pkg::SurrLo && shifted <= jse_pkg::SurrHi)) begin
                  inv = 1'b1;
               end
               code = 21'd0;
               cls  = 2'd0;
            end else begin
               code = shifted;
            end
         end
      end

      verdict_bad = inv | (pend != 2'd0);

      if (string_end) begin
         pend_in  = 2'd0;
         code_in  = 21'd0;
         class_in = 2'd0;
         inv_in   = 1'b0;
      end else begin
         pend_in  = pend;
         code_in  = code;
         class_in = cls;
         inv_in   = inv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 2'd0;
         code_ff  <= 21'd0;
         class_ff <= 2'd0;
         inv_ff   <= 1'b0;
      end else if (accept) begin
         pend_ff  <= pend_in;
         code_ff  <= code_in;
         class_ff <= class_in;
         inv_ff   <= inv_in;
      end
   end

endmodule

FILE: design/jse_expand.sv
module jse_expand (
   input  logic             [7:0] data_byte,
   input  logic                   byte_present,
   input  logic                   string_start,
   input  logic                   string_end,
   input  logic                   verdict_bad,
   output jse_pkg::seq_type       seq
);

   logic [jse_pkg::CntBits-1:0] n;
   logic [7:0]                  esc;

   always_comb begin
      seq = '0;
      n   = '0;
      case (data_byte)
         jse_pkg::ChQuote:     esc = jse_pkg::ChQuote;
         jse_pkg::ChBackslash: esc = jse_pkg::ChBackslash;
         jse_pkg::CtlLf:       esc = 8'h6e;
         jse_pkg::CtlCr:       esc = 8'h72;
         jse_pkg::CtlTab:      esc = 8'h74;
         jse_pkg::CtlBs:       esc = 8'h62;
         jse_pkg::CtlFf:       esc = 8'h66;
         default:              esc = 8'h00;
      endcase

      if (string_start) begin
         seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChQuote;
         n = n + 1'b1;
      end
      if (byte_present) begin
         if (esc != 8'h00) begin
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChBackslash;
            n = n + 1'b1;
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = esc;
            n = n + 1'b1;
         end else if (data_byte < 8'h20) begin
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChBackslash;
            n = n + 1'b1;
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChLower_u;
            n = n + 1'b1;
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChZero;
            n = n + 1'b1;
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChZero;
            n = n + 1'b1;
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::hex_digit(data_byte[7:4]);
            n = n + 1'b1;
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::hex_digit(data_byte[3:0]);
            n = n + 1'b1;
         end else begin
            seq.bytes[n[jse_pkg::IdxBits-1:0]] = data_byte;
            n = n + 1'b1;
         end
      end
      if (string_end) begin
         seq.bytes[n[jse_pkg::IdxBits-1:0]] = jse_pkg::ChQuote;
         n = n + 1'b1;
      end
      seq.count     = n;
      seq.has_close = string_end;
      seq.bad       = verdict_bad;
   end

endmodule

FILE: design/jse_out_buffer.sv
module jse_out_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  jse_pkg::seq_type seq,
   output logic             can_load,
   jse_rsp_if.source        rsp_bus
);

   jse_pkg::seq_type            seq_ff;
   logic [jse_pkg::IdxBits-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic                        at_last;
   logic                        take;

   assign at_last  = ({1'b0, idx_ff} + 1'b1) == seq_ff.count;
   assign take     = valid_ff && rsp_bus.ready;
   assign can_load = !valid_ff || (take && at_last);

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (take) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load && seq.count != '0) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      if (load && seq.count != '0) begin
         seq_ff <= seq;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.out_byte      = seq_ff.bytes[idx_ff];
   assign rsp_bus.out_last      = at_last;
   assign rsp_bus.closing_quote = at_last && seq_ff.has_close;
   assign rsp_bus.utf8_invalid  = at_last && seq_ff.has_close && seq_ff.bad;

endmodule

FILE: design/json_string_escaper_utf8_check_unit.sv
// JSON string escaper with strict UTF-8 check.
// req_bus: one beat per string byte, with byte_present, string_start and
//   string_end marks. rsp_bus: the quoted, escaped text, one byte per beat;
//   out_last marks the final beat of an input beat, closing_quote marks the
//   closing quote and utf8_invalid on it gives the verdict for the string.
// An accepted beat is escaped and checked in the accepting cycle and its
//   bytes land in an 8-byte expansion register; the first output beat shows
//   in the cycle after acceptance.
// Throughput: an input beat that yields n output bytes (1 to 8) holds the
//   output until all n are taken; the next input beat is taken in the
//   cycle the last of them is, so plain bytes flow at one per cycle
//   unless stalled. A beat with no output is taken when the buffer can load.
// Reset clears the UTF-8 checker state and drops any buffered bytes.
// When rsp_bus.ready is low the current byte holds and req_bus.ready drops
//   once the buffered beat is not yet fully drained.
module json_string_escaper_utf8_check_unit (
   input  logic       clock,
   input  logic       reset,
   jse_req_if.sink    req_bus,
   jse_rsp_if.source  rsp_bus
);

   logic             accept;
   logic             can_load;
   logic             verdict_bad;
   jse_pkg::seq_type seq;

   assign req_bus.ready = can_load;
   assign accept        = req_bus.valid && can_load;

   jse_utf8_check u_check (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_bus.data_byte),
      .byte_present (req_bus.byte_present),
      .string_start (req_bus.string_start),
      .string_end   (req_bus.string_end),
      .verdict_bad  (verdict_bad)
   );

   jse_expand u_expand (
      .data_byte    (req_bus.data_byte),
      .byte_present (req_bus.byte_present),
      .string_start (req_bus.string_start),
      .string_end   (req_bus.string_end),
      .verdict_bad  (verdict_bad),
      .seq          (seq)
   );

   jse_out_buffer u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .seq      (seq),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: design/jse_checker.sv
module jse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_closing_quote,
   input logic       rsp_utf8_invalid
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("rsp beat changed while stalled");

   a_ready_only_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !(rsp_ready && rsp_out_last))
      else $error("input stalled with no pending output");

   a_close_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_closing_quote |-> rsp_out_last && rsp_out_byte == jse_pkg::ChQuote)
      else $error("closing quote not a final quote beat");

   a_verdict_on_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_utf8_invalid |-> rsp_closing_quote)
      else $error("utf8_invalid outside closing quote");

endmodule

bind json_string_escaper_utf8_check_unit jse_checker u_jse_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_out_byte      (rsp_bus.out_byte),
   .rsp_out_last      (rsp_bus.out_last),
   .rsp_closing_quote (rsp_bus.closing_quote),
   .rsp_utf8_invalid  (rsp_bus.utf8_invalid)
);
